>>> rtl/imhq_pkg.sv
package imhq_pkg;

    localparam int CAPACITY  = 256;
    localparam int TAG_BITS  = 10;
    localparam int KEY_BITS  = 32;
    localparam int PAY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int TAG_COUNT = 1 << TAG_BITS;
    localparam int ENTRY_BITS = TAG_BITS + KEY_BITS + PAY_BITS;

    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REKEY  = 2'd1;
    localparam op_t OP_DELMIN = 2'd2;
    localparam op_t OP_REMOVE = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_DUP      = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [TAG_BITS-1:0]        tag;
        logic signed [KEY_BITS-1:0] key;
        logic [PAY_BITS-1:0]        pay;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_RDTARGET,
        S_RDLAST,
        S_DISPATCH,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } state_t;

endpackage

>>> rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap queue. An error result skips the heap entirely; a sift
// up reads one parent per level, and a sift down reads the left child and, when it
// exists, the right child per level.
// Throughput: one item at a time, the next taken the cycle after the prior result is
// registered; a stalled result holds back only the following result.
// Reset: control and count clear at once; position map then swept to zero, input stalled meanwhile.
module indexed_min_heap_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [imhq_pkg::TAG_BITS-1:0]       tag,
    input  logic signed [imhq_pkg::KEY_BITS-1:0] priority_req,
    input  logic [imhq_pkg::PAY_BITS-1:0]       payload,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [imhq_pkg::TAG_BITS-1:0]       out_tag,
    output logic signed [imhq_pkg::KEY_BITS-1:0] out_priority,
    output logic [imhq_pkg::PAY_BITS-1:0]       out_payload
);

    localparam int SB = imhq_pkg::SLOT_BITS;
    localparam int AB = imhq_pkg::ADDR_BITS;
    localparam int TB = imhq_pkg::TAG_BITS;

    // Heap memory, slot s stored at address s-1
    logic                 h_we;
    logic [AB-1:0]        h_waddr, h_raddr;
    imhq_pkg::entry_t     h_wdata, h_rdata;

    imhq_ram #(.WIDTH(imhq_pkg::ENTRY_BITS), .DEPTH(imhq_pkg::CAPACITY)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    // Position map, tag to slot (0 means absent)
    logic                 p_we;
    logic [TB-1:0]        p_waddr, p_raddr;
    logic [SB-1:0]        p_wdata, p_rdata;

    imhq_ram #(.WIDTH(SB), .DEPTH(imhq_pkg::TAG_COUNT)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    imhq_pkg::state_t     state_reg, state_next;
    logic                 clr_reg, clr_next;
    logic [TB:0]          clr_cnt_reg, clr_cnt_next;
    logic [SB-1:0]        count_reg, count_next;
    logic [1:0]           op_reg, op_next;
    logic [TB-1:0]        tag_reg, tag_next;
    logic signed [imhq_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [imhq_pkg::PAY_BITS-1:0] pay_reg, pay_next;
    logic [SB-1:0]        pos_reg, pos_next;
    imhq_pkg::entry_t     e_reg, e_next;      // entry being sifted
    imhq_pkg::entry_t     gone_reg, gone_next;
    imhq_pkg::entry_t     c1_reg, c1_next;    // chosen child
    logic                 rsel_reg, rsel_next; // chosen child is the right one
    logic                 up_reg, up_next;    // sift direction
    logic                 ov_reg, ov_next;
    logic [2:0]           st_reg, st_next;
    imhq_pkg::entry_t     res_reg, res_next;
    logic [2:0]           ost_reg, ost_next;  // output register
    imhq_pkg::entry_t     ores_reg, ores_next;

    assign in_stall     = (state_reg != imhq_pkg::S_IDLE) || clr_reg;
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign out_tag      = ores_reg.tag;
    assign out_priority = ores_reg.key;
    assign out_payload  = ores_reg.pay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= imhq_pkg::S_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            count_reg   <= count_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        pos_reg  <= pos_next;
        e_reg    <= e_next;
        gone_reg <= gone_next;
        c1_reg   <= c1_next;
        rsel_reg <= rsel_next;
        up_reg   <= up_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
        ost_reg  <= ost_next;
        ores_reg <= ores_next;
    end

    // Next state, memory control and result
    always_comb
    begin
        logic [SB:0] cpos;
        state_next   = state_reg;
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        tag_next     = tag_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        pos_next     = pos_reg;
        e_next       = e_reg;
        gone_next    = gone_reg;
        c1_next      = c1_reg;
        rsel_next    = rsel_reg;
        up_next      = up_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        ost_next     = ost_reg;
        ores_next    = ores_reg;
        ov_next      = ov_reg && out_stall;
        h_we         = 1'b0;
        h_waddr      = '0;
        h_wdata      = e_reg;
        h_raddr      = '0;
        p_we         = 1'b0;
        p_waddr      = e_reg.tag;
        p_wdata      = pos_reg;
        p_raddr      = tag_reg;
        cpos         = {pos_reg, 1'b0};

        // Position map clearing sweep
        if (clr_reg)
        begin
            p_we         = 1'b1;
            p_waddr      = clr_cnt_reg[TB-1:0];
            p_wdata      = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (TB+1)'(imhq_pkg::TAG_COUNT - 1))
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            imhq_pkg::S_IDLE:
            begin
                if (in_valid && !clr_reg)
                begin
                    op_next   = op;
                    tag_next  = tag;
                    key_next  = priority_req;
                    pay_next  = payload;
                    state_next = imhq_pkg::S_LOOKUP;
                end
            end
            imhq_pkg::S_LOOKUP:
            begin
                // position map read issued here
                p_raddr    = tag_reg;
                state_next = imhq_pkg::S_CHECK;
            end
            imhq_pkg::S_CHECK:
            begin
                st_next  = imhq_pkg::ST_OK;
                res_next = '0;
                case (op_reg)
                    imhq_pkg::OP_INSERT:
                    begin
                        if (count_reg >= SB'(imhq_pkg::CAPACITY))
                        begin
                            st_next = imhq_pkg::ST_FULL;
                            state_next = imhq_pkg::S_DONE;
                        end
                        else if (p_rdata != '0)
                        begin
                            st_next = imhq_pkg::ST_DUP;
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            e_next     = '{tag: tag_reg, key: key_reg, pay: pay_reg};
                            res_next   = '{tag: tag_reg, key: key_reg, pay: pay_reg};
                            count_next = count_reg + 1'b1;
                            pos_next   = count_reg + 1'b1;
                            up_next    = 1'b1;
                            state_next = imhq_pkg::S_DISPATCH;
                        end
                    end
                    imhq_pkg::OP_DELMIN:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = imhq_pkg::ST_EMPTY;
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            pos_next   = SB'(1);
                            h_raddr    = '0;
                            state_next = imhq_pkg::S_RDTARGET;
                        end
                    end
                    default:
                    begin
                        if (p_rdata == '0 || p_rdata > count_reg)
                        begin
                            st_next = imhq_pkg::ST_NOTFOUND;
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            pos_next   = p_rdata;
                            h_raddr    = AB'(p_rdata - 1'b1);
                            state_next = imhq_pkg::S_RDTARGET;
                        end
                    end
                endcase
            end
            imhq_pkg::S_RDTARGET:
            begin
                gone_next = h_rdata;
                if (op_reg == imhq_pkg::OP_REKEY)
                begin
                    e_next     = '{tag: h_rdata.tag, key: key_reg, pay: h_rdata.pay};
                    res_next   = '{tag: h_rdata.tag, key: key_reg, pay: h_rdata.pay};
                    up_next    = key_reg < h_rdata.key;
                    state_next = (key_reg == h_rdata.key) ? imhq_pkg::S_PLACE
                                                          : imhq_pkg::S_DISPATCH;
                end
                else
                begin
                    res_next   = h_rdata;
                    h_raddr    = AB'(count_reg - 1'b1);
                    state_next = imhq_pkg::S_RDLAST;
                end
            end
            imhq_pkg::S_RDLAST:
            begin
                // clear the removed tag, shrink, move last into the hole
                p_we       = 1'b1;
                p_waddr    = gone_reg.tag;
                p_wdata    = '0;
                count_next = count_reg - 1'b1;
                e_next     = h_rdata;
                up_next    = h_rdata.key < gone_reg.key;
                if (pos_reg > count_reg - 1'b1)
                begin
                    state_next = imhq_pkg::S_DONE;
                end
                else if (h_rdata.key == gone_reg.key)
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
                else
                begin
                    state_next = imhq_pkg::S_DISPATCH;
                end
            end
            imhq_pkg::S_DISPATCH:
            begin
                if (up_reg)
                begin
                    if (pos_reg == SB'(1))
                    begin
                        state_next = imhq_pkg::S_PLACE;
                    end
                    else
                    begin
                        h_raddr    = AB'((pos_reg >> 1) - 1'b1);
                        state_next = imhq_pkg::S_UP_CMP;
                    end
                end
                else
                begin
                    if (cpos > {1'b0, count_reg})
                    begin
                        state_next = imhq_pkg::S_PLACE;
                    end
                    else
                    begin
                        h_raddr    = AB'(cpos - 1'b1);
                        state_next = imhq_pkg::S_DN_RD1;
                    end
                end
            end
            imhq_pkg::S_UP_CMP:
            begin
                if (e_reg.key < h_rdata.key)
                begin
                    // parent moves down into pos
                    h_we       = 1'b1;
                    h_waddr    = AB'(pos_reg - 1'b1);
                    h_wdata    = h_rdata;
                    p_we       = !clr_reg;
                    p_waddr    = h_rdata.tag;
                    p_wdata    = pos_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = imhq_pkg::S_DISPATCH;
                end
                else
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
            end
            imhq_pkg::S_DN_RD1:
            begin
                // left child in; read the right one when it exists
                c1_next   = h_rdata;
                rsel_next = 1'b0;
                if (cpos == {1'b0, count_reg})
                begin
                    state_next = imhq_pkg::S_DN_CMP;
                end
                else
                begin
                    h_raddr    = AB'(cpos);
                    state_next = imhq_pkg::S_DN_RD2;
                end
            end
            imhq_pkg::S_DN_RD2:
            begin
                // pick right child only if strictly smaller
                if (h_rdata.key < c1_reg.key)
                begin
                    c1_next   = h_rdata;
                    rsel_next = 1'b1;
                end
                state_next = imhq_pkg::S_DN_CMP;
            end
            imhq_pkg::S_DN_CMP:
            begin
                // chosen child moves up into pos when strictly smaller
                if (c1_reg.key < e_reg.key)
                begin
                    h_we       = 1'b1;
                    h_waddr    = AB'(pos_reg - 1'b1);
                    h_wdata    = c1_reg;
                    p_we       = 1'b1;
                    p_waddr    = c1_reg.tag;
                    p_wdata    = pos_reg;
                    pos_next   = SB'({pos_reg, rsel_reg});
                    state_next = imhq_pkg::S_DISPATCH;
                end
                else
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
            end
            imhq_pkg::S_PLACE:
            begin
                h_we       = 1'b1;
                h_waddr    = AB'(pos_reg - 1'b1);
                h_wdata    = e_reg;
                p_we       = 1'b1;
                p_waddr    = e_reg.tag;
                p_wdata    = pos_reg;
                state_next = imhq_pkg::S_DONE;
            end
            imhq_pkg::S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    ores_next  = res_reg;
                    state_next = imhq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = imhq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/imhq_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> verif/indexed_min_heap_queue_tb.sv
`timescale 1ns / 100ps

module indexed_min_heap_queue_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM = 370;

    typedef struct {
        imhq_pkg::op_t op;
        logic [imhq_pkg::TAG_BITS-1:0] tag;
        logic signed [imhq_pkg::KEY_BITS-1:0] key;
        logic [imhq_pkg::PAY_BITS-1:0] pay;
    } item_t;

    typedef struct {
        imhq_pkg::status_t st;
        logic [imhq_pkg::TAG_BITS-1:0] tag;
        logic signed [imhq_pkg::KEY_BITS-1:0] key;
        logic [imhq_pkg::PAY_BITS-1:0] pay;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = '0;
    logic [imhq_pkg::TAG_BITS-1:0] tag = '0;
    logic signed [imhq_pkg::KEY_BITS-1:0] priority_req = '0;
    logic [imhq_pkg::PAY_BITS-1:0] payload = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [imhq_pkg::TAG_BITS-1:0] out_tag;
    logic signed [imhq_pkg::KEY_BITS-1:0] out_priority;
    logic [imhq_pkg::PAY_BITS-1:0] out_payload;

    indexed_min_heap_queue dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow heap: slots 1..heap_count, tag -> slot map
    item_t heap_mem [1:imhq_pkg::CAPACITY];
    int slot_map [imhq_pkg::TAG_COUNT];
    int heap_count = 0;

    item_t pending_items [$];
    result_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    int issued = 0;          // items taken from the queue by the driver
    int received = 0;        // results checked by the monitor
    bit calm = 0;            // no random idling
    int hold_req = 0;        // receiver hold-off request count
    int hold_ack = 0;
    int hold_left = 0;
    int live_tags [$];       // tags believed present, for targeting

    task automatic report(input string what);
    begin
        errors++;
        $display("mismatch: %s at cycle %0d", what, cycles);
    end
    endtask

    function automatic void heap_place(int pos, item_t e);
        heap_mem[pos] = e;
        slot_map[e.tag] = pos;
    endfunction

    function automatic void heap_up(int pos);
        item_t e;
        e = heap_mem[pos];
        while (pos > 1 && e.key < heap_mem[pos / 2].key) begin
            heap_place(pos, heap_mem[pos / 2]);
            pos = pos / 2;
        end
        heap_place(pos, e);
    endfunction

    function automatic void heap_down(int pos);
        item_t e;
        int c;
        e = heap_mem[pos];
        while (pos * 2 <= heap_count) begin
            c = pos * 2;
            if (c != heap_count && heap_mem[c + 1].key < heap_mem[c].key)
                c++;
            if (!(heap_mem[c].key < e.key))
                break;
            heap_place(pos, heap_mem[c]);
            pos = c;
        end
        heap_place(pos, e);
    endfunction

    function automatic void heap_take(int pos);
        item_t gone;
        item_t last;
        gone = heap_mem[pos];
        last = heap_mem[heap_count];
        slot_map[gone.tag] = 0;
        heap_count--;
        if (pos <= heap_count) begin
            heap_place(pos, last);
            if (last.key < gone.key)
                heap_up(pos);
            else if (gone.key < last.key)
                heap_down(pos);
        end
    endfunction

    // predict the result of one accepted item and update the shadow heap
    function automatic result_t heap_predict(item_t it);
        result_t r;
        int pos;
        logic signed [imhq_pkg::KEY_BITS-1:0] old_key;
        r = '{imhq_pkg::ST_OK, '0, '0, '0};
        case (it.op)
            imhq_pkg::OP_INSERT:
                if (heap_count >= imhq_pkg::CAPACITY)
                    r.st = imhq_pkg::ST_FULL;
                else if (slot_map[it.tag] != 0)
                    r.st = imhq_pkg::ST_DUP;
                else begin
                    r = '{imhq_pkg::ST_OK, it.tag, it.key, it.pay};
                    heap_count++;
                    heap_place(heap_count, it);
                    heap_up(heap_count);
                end
            imhq_pkg::OP_REKEY: begin
                pos = slot_map[it.tag];
                if (pos == 0)
                    r.st = imhq_pkg::ST_NOTFOUND;
                else begin
                    old_key = heap_mem[pos].key;
                    heap_mem[pos].key = it.key;
                    r = '{imhq_pkg::ST_OK, heap_mem[pos].tag, it.key, heap_mem[pos].pay};
                    if (old_key < it.key)
                        heap_down(pos);
                    else if (it.key < old_key)
                        heap_up(pos);
                end
            end
            imhq_pkg::OP_DELMIN:
                if (heap_count == 0)
                    r.st = imhq_pkg::ST_EMPTY;
                else begin
                    r = '{imhq_pkg::ST_OK, heap_mem[1].tag, heap_mem[1].key,
                          heap_mem[1].pay};
                    heap_take(1);
                end
            default: begin
                pos = slot_map[it.tag];
                if (pos == 0)
                    r.st = imhq_pkg::ST_NOTFOUND;
                else begin
                    r = '{imhq_pkg::ST_OK, heap_mem[pos].tag, heap_mem[pos].key,
                          heap_mem[pos].pay};
                    heap_take(pos);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_tag();
        if (live_tags.size() != 0 && $urandom_range(0, 3) != 0)
            return live_tags[$urandom_range(0, live_tags.size() - 1)];
        return int'($urandom_range(0, imhq_pkg::TAG_COUNT - 1));
    endfunction

    task automatic push_item(imhq_pkg::op_t o, int t,
                             logic [31:0] k, logic [31:0] p);
    begin
        pending_items.push_back('{o, t[imhq_pkg::TAG_BITS-1:0], k, p});
        if (o == imhq_pkg::OP_INSERT)
            live_tags.push_back(t);
    end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL indexed_min_heap_queue");
            $finish;
        end
        cycles <= cycles + 1;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(heap_predict('{imhq_pkg::op_t'(op), tag,
                                                          priority_req, payload}));
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                    item_t it;
                    it = pending_items.pop_front();
                    issued++;
                    in_valid <= 1'b1;
                    op <= it.op;
                    tag <= it.tag;
                    priority_req <= it.key;
                    payload <= it.pay;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0)
                    report("result with nothing expected");
                else begin
                    e = expected_results.pop_front();
                    received++;
                    if (status !== e.st)
                        report($sformatf("status %0d, want %0d", status, e.st));
                    if (out_tag !== e.tag)
                        report($sformatf("tag %0d, want %0d", out_tag, e.tag));
                    if (out_priority !== e.key)
                        report($sformatf("key %0d, want %0d", out_priority, e.key));
                    if (out_payload !== e.pay)
                        report($sformatf("payload %h, want %h", out_payload, e.pay));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_left <= 3000;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && $urandom_range(0, 99) < 29;
        end
    end

    task automatic wait_drained();
    begin
        while (pending_items.size() != 0 || issued != received)
            @(posedge clk);
    end
    endtask

    initial
    begin
        for (int i = 0; i < imhq_pkg::TAG_COUNT; i++)
            slot_map[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, extremes, ties, every op
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        push_item(imhq_pkg::OP_REMOVE, 5, 0, 0);
        push_item(imhq_pkg::OP_REKEY, 5, 0, 0);
        push_item(imhq_pkg::OP_INSERT, 0, 32'h7fff_ffff, 32'hffff_ffff);
        push_item(imhq_pkg::OP_INSERT, 0, 1, 1);
        push_item(imhq_pkg::OP_INSERT, 1023, 32'h8000_0000, 0);
        push_item(imhq_pkg::OP_INSERT, 7, 5, 32'haaaa_5555);
        push_item(imhq_pkg::OP_INSERT, 8, 5, 32'h5555_aaaa);
        push_item(imhq_pkg::OP_INSERT, 9, 5, 3);
        push_item(imhq_pkg::OP_REKEY, 9, 5, 0);
        push_item(imhq_pkg::OP_REKEY, 0, 32'hffff_fff0, 0);
        push_item(imhq_pkg::OP_REKEY, 1023, 32'h7fff_ffff, 0);
        push_item(imhq_pkg::OP_REMOVE, 8, 0, 0);
        push_item(imhq_pkg::OP_REMOVE, 8, 0, 0);
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        wait_drained();

        // fill to capacity under a long receiver hold-off, then overflow
        hold_req++;
        for (int i = 0; i < imhq_pkg::CAPACITY + 2; i++)
            push_item(imhq_pkg::OP_INSERT, i * 3, rand_word(), $urandom);
        wait_drained();
        for (int i = 0; i < imhq_pkg::CAPACITY + 1; i++)
            push_item(imhq_pkg::OP_DELMIN, 0, 0, 0);
        wait_drained();
        live_tags.delete();

        // random mix with a calm stretch in the middle
        for (int n = 0; n < NUM_RANDOM; n++) begin
            int sel;
            calm = (n >= 150 && n < 300);
            sel = $urandom_range(0, 99);
            if (sel < 40)
                push_item(imhq_pkg::OP_INSERT, pick_tag(), rand_word(), $urandom);
            else if (sel < 60)
                push_item(imhq_pkg::OP_REKEY, pick_tag(), rand_word(), $urandom);
            else if (sel < 80)
                push_item(imhq_pkg::OP_DELMIN, $urandom, $urandom, $urandom);
            else
                push_item(imhq_pkg::OP_REMOVE, pick_tag(), $urandom, $urandom);
            if (live_tags.size() > 200)
                live_tags.delete(0);
            while (pending_items.size() > 8)
                @(posedge clk);
        end
        calm = 0;
        wait_drained();
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("PASS indexed_min_heap_queue");
        else
            $display("FAIL indexed_min_heap_queue");
        $finish;
    end
endmodule
